@@ rtl/core/i2cts_pkg.sv @@
// Shared types and constants of the temperature sensor read sequencer.
package i2cts_pkg;

    // Bus commands issued to the byte engine
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_RD_ACK  = 3'd3,
        CMD_RD_NACK = 3'd4,
        CMD_STOP    = 3'd5,
        CMD_RECOVER = 3'd6
    } cmd_t;

    // Configuration port geometry
    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 9;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_FAULT_THRESHOLD = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_LIMIT   = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS  = 8'd2;
    localparam logic [CfgIdxW-1:0] CFG_REGISTER_INDEX  = 8'd3;

    // Configuration reset values
    localparam logic signed [8:0] FAULT_THRESHOLD_RST = 9'sd80;
    localparam logic [7:0]        TIMEOUT_LIMIT_RST   = 8'd2;
    localparam logic [6:0]        DEVICE_ADDRESS_RST  = 7'd76;
    localparam logic [7:0]        REGISTER_INDEX_RST  = 8'd0;

    // Saturation value of the tick counter
    localparam logic [7:0] TICKS_MAX = 8'hFF;

    typedef struct packed {
        logic signed [8:0] fault_threshold;
        logic [7:0]        timeout_limit;
        logic [6:0]        device_address;
        logic [7:0]        register_index;
    } cfg_t;

    typedef struct packed {
        logic       bus_ready;
        logic [7:0] read_byte;
        logic       tick;
    } poll_t;

    typedef struct packed {
        cmd_t              command;
        logic [7:0]        write_byte;
        logic signed [7:0] temperature;
        logic              fault;
    } result_t;

endpackage

@@ rtl/core/i2cts_poll_if.sv @@
// Poll item channel: bus status from the byte engine.
interface i2cts_poll_if;
    logic       valid;
    logic       ready;
    logic       bus_ready;
    logic [7:0] read_byte;
    logic       tick;

    modport source (output valid, output bus_ready, output read_byte, output tick,
                    input ready);
    modport sink   (input valid, input bus_ready, input read_byte, input tick,
                    output ready);
endinterface

@@ rtl/core/i2cts_result_if.sv @@
// Result item channel: bus command and temperature status.
interface i2cts_result_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic [7:0]        write_byte;
    logic signed [7:0] temperature;
    logic              fault;

    modport source (output valid, output command, output write_byte,
                    output temperature, output fault, input ready);
    modport sink   (input valid, input command, input write_byte,
                    input temperature, input fault, output ready);
endinterface

@@ rtl/core/i2cts_cfg_if.sv @@
// Configuration write channel.
interface i2cts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [i2cts_pkg::CfgIdxW-1:0]   index;
    logic [i2cts_pkg::CfgDataW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/i2c_temp_sensor_read_sequencer.sv @@
// Top level of the temperature sensor read sequencer.
//
//   channel  role    dir   payload
//   req      poll    in    bus_ready, read_byte, tick
//   rsp      result  out   command, write_byte, temperature, fault
//   cfg      config  in    index, data (always ready)
//
// One poll item is taken every cycle while the result side is not stalled; its result
// is presented on rsp once it has passed the poll register and then the result
// register in the phase machine.
// Throughput is set by the combinational phase update between those registers.
// Reset (rst_n low, async) returns to the start phase with cleared counters
// and the configuration reset values. A stalled result holds its register
// while one further item waits in the poll register.
module i2c_temp_sensor_read_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    i2cts_cfg_if.sink      cfg,
    i2cts_poll_if.sink     req,
    i2cts_result_if.source rsp
);

    logic                in_valid_reg,  in_valid_next;
    i2cts_pkg::poll_t    in_item_reg;
    logic                out_valid_reg, out_valid_next;
    logic                step;
    logic                in_take;
    i2cts_pkg::cfg_t     cfg_q;
    i2cts_pkg::result_t  result;

    // Pipeline handshake
    assign step           = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready      = !in_valid_reg || step;
    assign in_take        = req.valid && req.ready;
    assign in_valid_next  = in_take || (in_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && !rsp.ready);

    // Poll register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.bus_ready <= req.bus_ready;
            in_item_reg.read_byte <= req.read_byte;
            in_item_reg.tick      <= req.tick;
        end
    end

    i2cts_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    i2cts_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .poll   (in_item_reg),
        .cfg_q  (cfg_q),
        .result (result)
    );

    // Result channel
    assign rsp.valid       = out_valid_reg;
    assign rsp.command     = result.command;
    assign rsp.write_byte  = result.write_byte;
    assign rsp.temperature = result.temperature;
    assign rsp.fault       = result.fault;

endmodule

@@ rtl/core/i2cts_cfg_regs.sv @@
// Configuration register file of the sequencer.
module i2cts_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    i2cts_cfg_if.sink            cfg,
    output i2cts_pkg::cfg_t      cfg_q
);

    i2cts_pkg::cfg_t cfg_reg;
    i2cts_pkg::cfg_t cfg_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                i2cts_pkg::CFG_FAULT_THRESHOLD: cfg_next.fault_threshold = $signed(cfg.data);
                i2cts_pkg::CFG_TIMEOUT_LIMIT:   cfg_next.timeout_limit   = cfg.data[7:0];
                i2cts_pkg::CFG_DEVICE_ADDRESS:  cfg_next.device_address  = cfg.data[6:0];
                i2cts_pkg::CFG_REGISTER_INDEX:  cfg_next.register_index  = cfg.data[7:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fault_threshold <= i2cts_pkg::FAULT_THRESHOLD_RST;
            cfg_reg.timeout_limit   <= i2cts_pkg::TIMEOUT_LIMIT_RST;
            cfg_reg.device_address  <= i2cts_pkg::DEVICE_ADDRESS_RST;
            cfg_reg.register_index  <= i2cts_pkg::REGISTER_INDEX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/i2cts_seq.sv @@
// Phase machine: one poll item per step, result registered.
module i2cts_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  i2cts_pkg::poll_t     poll,
    input  i2cts_pkg::cfg_t      cfg_q,
    output i2cts_pkg::result_t   result
);

    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_W_START   = 3'd1,
        PH_W_ADDR_W  = 3'd2,
        PH_W_REG     = 3'd3,
        PH_W_RESTART = 3'd4,
        PH_W_ADDR_R  = 3'd5,
        PH_W_HIGH    = 3'd6,
        PH_W_LOW     = 3'd7
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic [7:0]          elapsed_reg, elapsed_next;
    logic signed [7:0]   temp_reg,    temp_next;
    logic                tmo_reg,     tmo_next;
    i2cts_pkg::result_t  result_reg,  result_next;
    logic [7:0]          elapsed_inc;

    assign result = result_reg;

    // Next phase, command and status for the current poll
    always_comb
    begin
        elapsed_inc = (poll.tick && (elapsed_reg != i2cts_pkg::TICKS_MAX))
                      ? elapsed_reg + 8'd1 : elapsed_reg;
        phase_next   = phase_reg;
        elapsed_next = elapsed_inc;
        temp_next    = temp_reg;
        tmo_next     = tmo_reg;
        result_next.command    = i2cts_pkg::CMD_NONE;
        result_next.write_byte = 8'h00;

        if (phase_reg == PH_START)
        begin
            result_next.command = i2cts_pkg::CMD_START;
            phase_next          = PH_W_START;
            elapsed_next        = 8'd0;
        end
        else if (poll.bus_ready)
        begin
            // ready wins over a timeout on the same poll
            elapsed_next = 8'd0;
            unique case (phase_reg)
                PH_W_START:
                begin
                    result_next.command    = i2cts_pkg::CMD_WRITE;
                    result_next.write_byte = {cfg_q.device_address, 1'b0};
                    phase_next             = PH_W_ADDR_W;
                end
                PH_W_ADDR_W:
                begin
                    result_next.command    = i2cts_pkg::CMD_WRITE;
                    result_next.write_byte = cfg_q.register_index;
                    phase_next             = PH_W_REG;
                end
                PH_W_REG:
                begin
                    result_next.command = i2cts_pkg::CMD_START;
                    phase_next          = PH_W_RESTART;
                end
                PH_W_RESTART:
                begin
                    result_next.command    = i2cts_pkg::CMD_WRITE;
                    result_next.write_byte = {cfg_q.device_address, 1'b1};
                    phase_next             = PH_W_ADDR_R;
                end
                PH_W_ADDR_R:
                begin
                    result_next.command = i2cts_pkg::CMD_RD_ACK;
                    phase_next          = PH_W_HIGH;
                end
                PH_W_HIGH:
                begin
                    result_next.command = i2cts_pkg::CMD_RD_NACK;
                    temp_next           = $signed(poll.read_byte);
                    phase_next          = PH_W_LOW;
                end
                default:
                begin
                    // low byte is dropped; stop ends the read and clears timeout
                    result_next.command = i2cts_pkg::CMD_STOP;
                    tmo_next            = 1'b0;
                    phase_next          = PH_START;
                end
            endcase
        end
        else if (elapsed_inc >= cfg_q.timeout_limit)
        begin
            result_next.command = i2cts_pkg::CMD_RECOVER;
            tmo_next            = 1'b1;
            phase_next          = PH_START;
        end

        result_next.temperature = temp_next;
        result_next.fault = tmo_next ||
                            ($signed({temp_next[7], temp_next}) >= cfg_q.fault_threshold);
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            elapsed_reg <= 8'd0;
            temp_reg    <= 8'sd0;
            tmo_reg     <= 1'b0;
            result_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            temp_reg    <= temp_next;
            tmo_reg     <= tmo_next;
            result_reg  <= result_next;
        end
    end

endmodule

@@ bench/tb_i2c_temp_sensor_read_sequencer.sv @@
// Testbench for the temperature sensor read sequencer: random polls checked against a predictor.
`timescale 1ns / 100ps

module tb_i2c_temp_sensor_read_sequencer;

    // Phases of the read sequence as tracked by the predictor
    typedef enum logic [2:0] {
        PH_START,
        PH_WAIT_START,
        PH_WAIT_ADDR_W,
        PH_WAIT_REG,
        PH_WAIT_RESTART,
        PH_WAIT_ADDR_R,
        PH_WAIT_HIGH,
        PH_WAIT_LOW
    } seq_phase_t;

    // Register indexes that map to nothing
    localparam logic [i2cts_pkg::CfgIdxW-1:0] CFG_IDX_PAST_END = 8'd4;
    localparam logic [i2cts_pkg::CfgIdxW-1:0] CFG_IDX_TOP      = 8'hFF;

    localparam int SEGMENTS     = 7;
    localparam int SEG_POLLS    = 175;
    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE_TICKS = 4;

    logic clk;
    logic rst_n;

    i2cts_cfg_if    cfg_ch ();
    i2cts_poll_if   poll_ch ();
    i2cts_result_if res_ch ();

    i2c_temp_sensor_read_sequencer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (poll_ch),
        .rsp   (res_ch)
    );

    // Predictor state and configuration copy
    seq_phase_t         mdl_phase;
    logic [7:0]         mdl_ticks;
    logic signed [7:0]  mdl_temp;
    logic               mdl_timeout;
    i2cts_pkg::cfg_t    mdl_cfg;

    i2cts_pkg::poll_t   pending_polls[$];
    i2cts_pkg::result_t expected_bus_ops[$];

    int  mismatch_count;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    int  rsp_hold_left;
    logic poll_taken;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic void reset_predictor();
        mdl_phase                   = PH_START;
        mdl_ticks                   = '0;
        mdl_temp                    = '0;
        mdl_timeout                 = 1'b0;
        mdl_cfg.fault_threshold     = i2cts_pkg::FAULT_THRESHOLD_RST;
        mdl_cfg.timeout_limit       = i2cts_pkg::TIMEOUT_LIMIT_RST;
        mdl_cfg.device_address      = i2cts_pkg::DEVICE_ADDRESS_RST;
        mdl_cfg.register_index      = i2cts_pkg::REGISTER_INDEX_RST;
    endfunction

    // One poll through the sequencer: next bus command and status
    function automatic i2cts_pkg::result_t sequencer_step(input i2cts_pkg::poll_t p);
        i2cts_pkg::result_t r;
        i2cts_pkg::cmd_t    op;
        logic [7:0]         wb;
        op = i2cts_pkg::CMD_NONE;
        wb = '0;
        if (p.tick && mdl_ticks != i2cts_pkg::TICKS_MAX)
            mdl_ticks = mdl_ticks + 8'd1;
        if (mdl_phase == PH_START)
        begin
            op        = i2cts_pkg::CMD_START;
            mdl_phase = PH_WAIT_START;
            mdl_ticks = '0;
        end
        else if (p.bus_ready)
        begin
            // ready wins over a timeout on the same poll
            case (mdl_phase)
                PH_WAIT_START:
                begin
                    op = i2cts_pkg::CMD_WRITE;
                    wb = {mdl_cfg.device_address, 1'b0};
                end
                PH_WAIT_ADDR_W:
                begin
                    op = i2cts_pkg::CMD_WRITE;
                    wb = mdl_cfg.register_index;
                end
                PH_WAIT_REG:
                    op = i2cts_pkg::CMD_START;
                PH_WAIT_RESTART:
                begin
                    op = i2cts_pkg::CMD_WRITE;
                    wb = {mdl_cfg.device_address, 1'b1};
                end
                PH_WAIT_ADDR_R:
                    op = i2cts_pkg::CMD_RD_ACK;
                PH_WAIT_HIGH:
                begin
                    op       = i2cts_pkg::CMD_RD_NACK;
                    mdl_temp = p.read_byte;
                end
                default:
                begin
                    op          = i2cts_pkg::CMD_STOP;
                    mdl_timeout = 1'b0;
                end
            endcase
            mdl_phase = (mdl_phase == PH_WAIT_LOW) ? PH_START : seq_phase_t'(mdl_phase + 3'd1);
            mdl_ticks = '0;
        end
        else if (mdl_ticks >= mdl_cfg.timeout_limit)
        begin
            op          = i2cts_pkg::CMD_RECOVER;
            mdl_timeout = 1'b1;
            mdl_phase   = PH_START;
        end
        r.command     = op;
        r.write_byte  = wb;
        r.temperature = mdl_temp;
        r.fault       = mdl_timeout || ($signed(mdl_temp) >= $signed(mdl_cfg.fault_threshold));
        return r;
    endfunction

    // Poll driver: fed from pending_polls, changes on the falling edge
    always @(negedge clk)
    begin : poll_driver
        i2cts_pkg::poll_t nxt;
        if (!rst_n)
            poll_ch.valid <= 1'b0;
        else if (poll_ch.valid && !poll_taken)
            ;   // hold the offered item
        else if (pending_polls.size() != 0 && $urandom_range(99) >= snd_idle_pct)
        begin
            nxt = pending_polls.pop_front();
            poll_ch.valid     <= 1'b1;
            poll_ch.bus_ready <= nxt.bus_ready;
            poll_ch.read_byte <= nxt.read_byte;
            poll_ch.tick      <= nxt.tick;
        end
        else
            poll_ch.valid <= 1'b0;
    end

    // Result receiver with random idling and an optional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (rsp_hold_left != 0)
        begin
            rsp_hold_left <= rsp_hold_left - 1;
            res_ch.ready  <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Monitor: check results, predict accepted polls, track register writes
    always @(posedge clk)
    begin : monitor
        i2cts_pkg::result_t want;
        if (!rst_n)
            poll_taken = 1'b0;
        else
        begin
            // results first: they belong to polls accepted earlier
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_bus_ops.size() == 0)
                    report_mismatch("result with nothing pending", res_ch.command, 0);
                else
                begin
                    want = expected_bus_ops.pop_front();
                    if (res_ch.command !== want.command)
                        report_mismatch("command", res_ch.command, want.command);
                    if (res_ch.write_byte !== want.write_byte)
                        report_mismatch("write_byte", res_ch.write_byte, want.write_byte);
                    if (res_ch.temperature !== want.temperature)
                        report_mismatch("temperature", res_ch.temperature, want.temperature);
                    if (res_ch.fault !== want.fault)
                        report_mismatch("fault", res_ch.fault, want.fault);
                end
            end
            poll_taken = poll_ch.valid && poll_ch.ready;
            if (poll_taken)
                expected_bus_ops.push_back(sequencer_step('{bus_ready: poll_ch.bus_ready,
                                                             read_byte: poll_ch.read_byte,
                                                             tick:      poll_ch.tick}));
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    i2cts_pkg::CFG_FAULT_THRESHOLD:
                        mdl_cfg.fault_threshold = cfg_ch.data;
                    i2cts_pkg::CFG_TIMEOUT_LIMIT:
                        mdl_cfg.timeout_limit   = cfg_ch.data[7:0];
                    i2cts_pkg::CFG_DEVICE_ADDRESS:
                        mdl_cfg.device_address  = cfg_ch.data[6:0];
                    i2cts_pkg::CFG_REGISTER_INDEX:
                        mdl_cfg.register_index  = cfg_ch.data[7:0];
                    default: ;
                endcase
            end
        end
    end

    task automatic queue_poll(input logic rdy, input logic [7:0] data, input logic tk);
        pending_polls.push_back('{bus_ready: rdy, read_byte: data, tick: tk});
    endtask

    // Bytes biased toward sign edges and the current threshold
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            3:       return 8'hFF;
            4:       return mdl_cfg.fault_threshold[7:0] - 8'($urandom_range(1));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Bursts of polls with varying ready and tick rates, plus some noise
    task automatic queue_random_polls(input int count);
        int ready_pct;
        int tick_pct;
        ready_pct = 90;
        tick_pct  = 20;
        for (int i = 0; i < count; i++)
        begin
            if (i % 24 == 0)
            begin
                case ($urandom_range(2))
                    0:       ready_pct = 95;
                    1:       ready_pct = 60;
                    default: ready_pct = 25;
                endcase
                case ($urandom_range(2))
                    0:       tick_pct = 10;
                    1:       tick_pct = 40;
                    default: tick_pct = 85;
                endcase
            end
            if ($urandom_range(99) < 8)
                queue_poll(1'($urandom_range(1)), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
            else
                queue_poll($urandom_range(99) < ready_pct, pick_byte(),
                           $urandom_range(99) < tick_pct);
        end
    endtask

    // Wait until every poll is accepted and every result has come back
    task automatic wait_quiet();
        while (pending_polls.size() != 0 || poll_ch.valid || expected_bus_ops.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (SETTLE_TICKS) @(posedge clk);
        #1;
    endtask

    task automatic cfg_write(input logic [i2cts_pkg::CfgIdxW-1:0] idx,
                             input logic [i2cts_pkg::CfgDataW-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        #1;
    endtask

    // Write all registers; unused upper data bits carry junk
    task automatic apply_setting(input logic [8:0] thr, input logic [7:0] lim,
                                 input logic [6:0] addr, input logic [7:0] ridx,
                                 input bit with_unmapped);
        cfg_write(i2cts_pkg::CFG_FAULT_THRESHOLD, thr);
        cfg_write(i2cts_pkg::CFG_TIMEOUT_LIMIT, {1'($urandom_range(1)), lim});
        cfg_write(i2cts_pkg::CFG_DEVICE_ADDRESS, {2'($urandom_range(3)), addr});
        cfg_write(i2cts_pkg::CFG_REGISTER_INDEX, {1'($urandom_range(1)), ridx});
        if (with_unmapped)
        begin
            cfg_write(CFG_IDX_PAST_END, 9'($urandom_range(511)));
            cfg_write(CFG_IDX_TOP, 9'($urandom_range(511)));
        end
    endtask

    // Stimulus sequence
    initial
    begin
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        poll_ch.valid     = 1'b0;
        poll_ch.bus_ready = 1'b0;
        poll_ch.read_byte = '0;
        poll_ch.tick      = 1'b0;
        res_ch.ready      = 1'b0;
        poll_taken        = 1'b0;
        mismatch_count    = 0;
        rsp_hold_left     = 0;
        snd_idle_pct      = 19;
        rcv_idle_pct      = 61;
        reset_predictor();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // Directed: full read at reset settings, threshold hit
        queue_poll(1'b0, 8'h00, 1'b0);
        repeat (5) queue_poll(1'b1, 8'h00, 1'b0);
        queue_poll(1'b1, 8'h50, 1'b0);
        queue_poll(1'b1, 8'hAA, 1'b1);
        // start ignores ticks; ready beats a limit reached on the same poll
        queue_poll(1'b0, 8'h00, 1'b1);
        queue_poll(1'b0, 8'h00, 1'b1);
        queue_poll(1'b1, 8'h00, 1'b1);
        // timeout then recovery
        queue_poll(1'b0, 8'h00, 1'b1);
        queue_poll(1'b0, 8'h00, 1'b0);
        queue_poll(1'b0, 8'h00, 1'b1);
        // read of the most negative temperature; stop clears the timeout
        queue_poll(1'b1, 8'hFF, 1'b1);
        repeat (5) queue_poll(1'b1, 8'h00, 1'b0);
        queue_poll(1'b1, 8'h80, 1'b0);
        queue_poll(1'b0, 8'h00, 1'b0);
        queue_poll(1'b1, 8'h7F, 1'b0);
        wait_quiet();

        // Random segments over several settings and idling modes
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 3)
            begin
                snd_idle_pct = 19;
                rcv_idle_pct = 61;
            end
            else if (seg < 5)
            begin
                snd_idle_pct = 61;
                rcv_idle_pct = 19;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            case (seg)
                1: apply_setting(9'h180, 8'd1, 7'd0, 8'hFF, 1'b1);
                2: apply_setting(9'h080, 8'd255, 7'd127, 8'h00, 1'b0);
                3: apply_setting(9'h000, 8'd0, 7'h55, 8'hA5, 1'b0);
                4: apply_setting(9'h0FF, 8'd3, 7'h2A, 8'h5A, 1'b1);
                5: apply_setting(9'h100, 8'd2, 7'($urandom_range(127)),
                                 8'($urandom_range(255)), 1'b0);
                6: apply_setting(9'($urandom_range(256) - 128), 8'($urandom_range(6, 1)),
                                 7'($urandom_range(127)), 8'($urandom_range(255)), 1'b1);
                default: ;
            endcase
            queue_random_polls(SEG_POLLS);
            wait_quiet();

            // Back-pressure: receiver holds off while polls keep coming
            if (seg == 2)
            begin
                snd_idle_pct  = 0;
                rsp_hold_left = HOLD_CYCLES;
                queue_random_polls(40);
                wait_quiet();
            end
        end

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
